### rtl/core/kpc_pkg.sv
// shared constants and types for the k-means point clustering unit
package kpc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int COORD_BITS   = 16;
  localparam int PT_AW        = $clog2(MAX_POINTS);
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int CNT_W        = PT_AW + 1;
  localparam int K_W          = CL_W + 1;
  localparam int SUM_W        = COORD_BITS + CNT_W;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int DIST_W       = 2 * DIFF_W;
  localparam int ITER_W       = 10;
  localparam int NC_W         = 5;
  localparam int CFG_W        = 10;
  localparam int DIV_STEPS    = SUM_W - 1;

  localparam logic CFG_NUM_CLUSTERS = 1'b0;
  localparam logic CFG_MAX_ITER     = 1'b1;
  localparam logic ACT_LOAD         = 1'b0;
  localparam logic ACT_READ         = 1'b1;

  localparam logic [NC_W-1:0]   NUM_CLUSTERS_RST = NC_W'(4);
  localparam logic [ITER_W-1:0] MAX_ITER_RST     = ITER_W'(100);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

### rtl/core/kpc_ram.sv
// generic single write port ram with registered read
module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kmeans_point_clustering_unit.sv
// k-means point clustering unit: point load, lloyd iterations, summary and read words
//
// Load words are taken while idle and go straight into the point memory. The word that
// carries last_point starts a run that holds in_ready low until every summary word is
// taken. A run first seeds the centres from the first K points; each iteration then makes
// an assignment pass through the single shared 17x17 multiplier, which works one axis of
// one centre at a time, followed by the centre update and iteration end through the
// bit-serial divider. K summary words follow, each held until out_ready takes it. A read
// word registers the point's assignment and then waits for the output handshake.
// Register writes are taken only while the unit is idle.
module kmeans_point_clustering_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic signed [15:0]               coord_x,
  input  logic signed [15:0]               coord_y,
  input  logic signed [15:0]               coord_z,
  input  logic                             last_point,
  input  logic [9:0]                       point_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       cluster_index,
  output logic [10:0]                      cluster_size,
  output logic signed [15:0]               center_x,
  output logic signed [15:0]               center_y,
  output logic signed [15:0]               center_z,
  output logic [3:0]                       point_cluster,
  output logic                             converged,
  output logic [9:0]                       iterations,
  output logic                             error,
  output logic                             last_result
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SEED, S_SEEDW, S_PT, S_PTW, S_MUL, S_ADD, S_CMP, S_ACCUM,
    S_DIV, S_DIVRUN, S_DIVEND, S_ITEND, S_EMIT, S_WAIT
  } state_t;

  state_t state;

  logic [kpc_pkg::NC_W-1:0]   num_clusters;
  logic [kpc_pkg::ITER_W-1:0] max_iterations;
  logic [kpc_pkg::CNT_W-1:0]  loaded;
  logic                       set_closed, overflowed, run_valid, run_conv;
  logic [kpc_pkg::K_W-1:0]    k;
  logic [kpc_pkg::ITER_W-1:0] limit;
  logic [kpc_pkg::ITER_W-1:0] iter;
  logic [kpc_pkg::K_W-1:0]    j;
  logic [1:0]                 a;
  logic [kpc_pkg::CNT_W-1:0]  i;
  logic                       first_iter, changed;
  kpc_pkg::point_t            p;
  logic [kpc_pkg::CL_W-1:0]   old_asg, best;
  logic [kpc_pkg::DIST_W-1:0] d, best_d, prod;
  logic [kpc_pkg::PT_AW-1:0]  rd_idx;

  kpc_pkg::point_t            centers [kpc_pkg::MAX_CLUSTERS];
  logic signed [kpc_pkg::SUM_W-1:0] sum_x [kpc_pkg::MAX_CLUSTERS];
  logic signed [kpc_pkg::SUM_W-1:0] sum_y [kpc_pkg::MAX_CLUSTERS];
  logic signed [kpc_pkg::SUM_W-1:0] sum_z [kpc_pkg::MAX_CLUSTERS];
  logic [kpc_pkg::CNT_W-1:0]  counts [kpc_pkg::MAX_CLUSTERS];

  logic [kpc_pkg::SUM_W-2:0]  div_num;
  logic [kpc_pkg::CNT_W-1:0]  div_rem;
  logic [4:0]                 div_step;
  logic                       div_neg;

  // memories
  logic                        pt_we;
  logic [kpc_pkg::PT_AW-1:0]   pt_waddr, pt_raddr;
  kpc_pkg::point_t             pt_wdata, pt_rdata;
  logic                        asg_we;
  logic [kpc_pkg::PT_AW-1:0]   asg_raddr;
  logic [kpc_pkg::CL_W-1:0]    asg_rdata;

  kpc_ram #(.WIDTH($bits(kpc_pkg::point_t)), .DEPTH(kpc_pkg::MAX_POINTS)) u_points (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  kpc_ram #(.WIDTH(kpc_pkg::CL_W), .DEPTH(kpc_pkg::MAX_POINTS)) u_assign (
    .clk(clk), .we(asg_we), .waddr(i[kpc_pkg::PT_AW-1:0]), .wdata(best),
    .raddr(asg_raddr), .rdata(asg_rdata)
  );

  // combinational helpers
  logic                        in_acc;
  logic [kpc_pkg::CNT_W-1:0]   cnt_base, cnt_new;
  logic                        ovf_new, room;
  logic [kpc_pkg::K_W-1:0]     k_eff;
  kpc_pkg::coord_t             pa, ca;
  logic signed [kpc_pkg::DIFF_W-1:0] diff;
  logic signed [kpc_pkg::DIST_W-1:0] sq;
  logic [kpc_pkg::DIST_W-1:0]  d_new;
  logic [kpc_pkg::CL_W-1:0]    row;
  logic signed [kpc_pkg::SUM_W-1:0] sum_sel, sum_abs;
  logic [kpc_pkg::CNT_W-1:0]   rem_sh;
  logic                        qbit;
  logic [kpc_pkg::CNT_W-1:0]   rem_next;
  kpc_pkg::coord_t             qval;
  logic [kpc_pkg::ITER_W:0]    iter_new;
  logic                        rd_ok;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    cnt_base = set_closed ? '0 : loaded;
    room     = (cnt_base < kpc_pkg::CNT_W'(kpc_pkg::MAX_POINTS));
    cnt_new  = room ? cnt_base + 1'b1 : cnt_base;
    ovf_new  = (set_closed ? 1'b0 : overflowed) || !room;
    if (num_clusters == '0) begin
      k_eff = kpc_pkg::K_W'(1);
    end else if (num_clusters > kpc_pkg::NC_W'(kpc_pkg::MAX_CLUSTERS)) begin
      k_eff = kpc_pkg::K_W'(kpc_pkg::MAX_CLUSTERS);
    end else begin
      k_eff = num_clusters[kpc_pkg::K_W-1:0];
    end

    pt_we    = in_acc && (action == kpc_pkg::ACT_LOAD) && room;
    pt_waddr = cnt_base[kpc_pkg::PT_AW-1:0];
    pt_wdata = '{x: coord_x, y: coord_y, z: coord_z};
    pt_raddr = (state == S_SEED) ? kpc_pkg::PT_AW'(j) : i[kpc_pkg::PT_AW-1:0];
    asg_raddr = (state == S_IDLE) ? point_index : i[kpc_pkg::PT_AW-1:0];
    asg_we   = (state == S_ACCUM) && (first_iter || (old_asg != best));

    case (a)
      2'd0:    begin pa = p.x; ca = centers[j[kpc_pkg::CL_W-1:0]].x; end
      2'd1:    begin pa = p.y; ca = centers[j[kpc_pkg::CL_W-1:0]].y; end
      default: begin pa = p.z; ca = centers[j[kpc_pkg::CL_W-1:0]].z; end
    endcase
    diff  = kpc_pkg::DIFF_W'(pa) - kpc_pkg::DIFF_W'(ca);
    sq    = diff * diff;
    d_new = d + prod;

    row = j[kpc_pkg::CL_W-1:0];
    case (a)
      2'd0:    sum_sel = sum_x[row];
      2'd1:    sum_sel = sum_y[row];
      default: sum_sel = sum_z[row];
    endcase
    sum_abs  = sum_sel[kpc_pkg::SUM_W-1] ? -sum_sel : sum_sel;
    rem_sh   = {div_rem[kpc_pkg::CNT_W-2:0], div_num[kpc_pkg::SUM_W-2]};
    qbit     = (rem_sh >= counts[row]);
    rem_next = qbit ? rem_sh - counts[row] : rem_sh;
    qval     = div_neg ? -kpc_pkg::COORD_BITS'(div_num) : kpc_pkg::COORD_BITS'(div_num);

    iter_new = {1'b0, iter} + 1'b1;
    rd_ok    = run_valid && ({1'b0, rd_idx} < loaded);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      num_clusters   <= kpc_pkg::NUM_CLUSTERS_RST;
      max_iterations <= kpc_pkg::MAX_ITER_RST;
      loaded         <= '0;
      set_closed     <= 1'b0;
      overflowed     <= 1'b0;
      run_valid      <= 1'b0;
      run_conv       <= 1'b0;
      iter           <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          kpc_pkg::CFG_NUM_CLUSTERS: num_clusters   <= cfg_data[kpc_pkg::NC_W-1:0];
          kpc_pkg::CFG_MAX_ITER:     max_iterations <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (action == kpc_pkg::ACT_READ) begin
              rd_idx <= point_index;
              state  <= S_READ;
            end else begin
              loaded     <= cnt_new;
              overflowed <= ovf_new;
              set_closed <= last_point;
              if (set_closed || last_point) begin
                run_valid <= 1'b0;
                run_conv  <= 1'b0;
              end
              if (last_point) begin
                k     <= k_eff;
                limit <= (max_iterations == '0) ? kpc_pkg::ITER_W'(1) : max_iterations;
                if (ovf_new || (cnt_new < kpc_pkg::CNT_W'(k_eff))) begin
                  iter          <= '0;
                  cluster_index <= '0;
                  cluster_size  <= '0;
                  center_x      <= '0;
                  center_y      <= '0;
                  center_z      <= '0;
                  point_cluster <= '0;
                  converged     <= 1'b0;
                  iterations    <= '0;
                  error         <= 1'b1;
                  last_result   <= 1'b1;
                  out_valid     <= 1'b1;
                  state         <= S_WAIT;
                end else begin
                  j          <= '0;
                  iter       <= '0;
                  first_iter <= 1'b1;
                  state      <= S_SEED;
                end
              end
            end
          end
        end
        S_READ: begin
          cluster_index <= '0;
          cluster_size  <= '0;
          center_x      <= '0;
          center_y      <= '0;
          center_z      <= '0;
          point_cluster <= rd_ok ? asg_rdata : '0;
          converged     <= 1'b0;
          iterations    <= '0;
          error         <= !rd_ok;
          last_result   <= 1'b1;
          out_valid     <= 1'b1;
          state         <= S_WAIT;
        end
        S_SEED: begin
          state <= S_SEEDW;
        end
        S_SEEDW: begin
          centers[row] <= pt_rdata;
          if (j + 1'b1 == k) begin
            i       <= '0;
            changed <= 1'b0;
            for (int c = 0; c < kpc_pkg::MAX_CLUSTERS; c++) begin
              sum_x[c]  <= '0;
              sum_y[c]  <= '0;
              sum_z[c]  <= '0;
              counts[c] <= '0;
            end
            state <= S_PT;
          end else begin
            j     <= j + 1'b1;
            state <= S_SEED;
          end
        end
        S_PT: begin
          state <= S_PTW;
        end
        S_PTW: begin
          p       <= pt_rdata;
          old_asg <= asg_rdata;
          j       <= '0;
          a       <= '0;
          d       <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          prod  <= kpc_pkg::DIST_W'(sq);
          state <= S_ADD;
        end
        S_ADD: begin
          d <= d_new;
          if (a == 2'd2) begin
            a     <= '0;
            state <= S_CMP;
          end else begin
            a     <= a + 1'b1;
            state <= S_MUL;
          end
        end
        S_CMP: begin
          if ((j == '0) || (d < best_d)) begin
            best   <= row;
            best_d <= d;
          end
          if (j + 1'b1 == k) begin
            state <= S_ACCUM;
          end else begin
            j     <= j + 1'b1;
            d     <= '0;
            state <= S_MUL;
          end
        end
        S_ACCUM: begin
          sum_x[best]  <= sum_x[best] + kpc_pkg::SUM_W'(p.x);
          sum_y[best]  <= sum_y[best] + kpc_pkg::SUM_W'(p.y);
          sum_z[best]  <= sum_z[best] + kpc_pkg::SUM_W'(p.z);
          counts[best] <= counts[best] + 1'b1;
          if (asg_we) begin
            changed <= 1'b1;
          end
          i <= i + 1'b1;
          if (i + 1'b1 == loaded) begin
            j     <= '0;
            a     <= '0;
            state <= S_DIV;
          end else begin
            state <= S_PT;
          end
        end
        S_DIV: begin
          if (j == k) begin
            state <= S_ITEND;
          end else if (counts[row] == '0) begin
            j <= j + 1'b1;
          end else begin
            div_num  <= sum_abs[kpc_pkg::SUM_W-2:0];
            div_neg  <= sum_sel[kpc_pkg::SUM_W-1];
            div_rem  <= '0;
            div_step <= '0;
            state    <= S_DIVRUN;
          end
        end
        S_DIVRUN: begin
          div_rem  <= rem_next;
          div_num  <= {div_num[kpc_pkg::SUM_W-3:0], qbit};
          div_step <= div_step + 1'b1;
          if (div_step == 5'(kpc_pkg::DIV_STEPS - 1)) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          case (a)
            2'd0:    centers[row].x <= qval;
            2'd1:    centers[row].y <= qval;
            default: centers[row].z <= qval;
          endcase
          if (a == 2'd2) begin
            a <= '0;
            j <= j + 1'b1;
          end else begin
            a <= a + 1'b1;
          end
          state <= S_DIV;
        end
        S_ITEND: begin
          iter       <= iter_new[kpc_pkg::ITER_W-1:0];
          first_iter <= 1'b0;
          if (!changed || (iter_new >= {1'b0, limit})) begin
            run_conv  <= !changed;
            run_valid <= 1'b1;
            j         <= '0;
            state     <= S_EMIT;
          end else begin
            i       <= '0;
            changed <= 1'b0;
            for (int c = 0; c < kpc_pkg::MAX_CLUSTERS; c++) begin
              sum_x[c]  <= '0;
              sum_y[c]  <= '0;
              sum_z[c]  <= '0;
              counts[c] <= '0;
            end
            state <= S_PT;
          end
        end
        S_EMIT: begin
          cluster_index <= row;
          cluster_size  <= counts[row];
          center_x      <= centers[row].x;
          center_y      <= centers[row].y;
          center_z      <= centers[row].z;
          point_cluster <= '0;
          converged     <= run_conv;
          iterations    <= iter;
          error         <= 1'b0;
          last_result   <= (j + 1'b1 == k);
          out_valid     <= 1'b1;
          state         <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/kmeans_point_clustering_unit_tb.sv
// testbench for the k-means point clustering unit: point sets, cluster reads, register settings
`timescale 1ns / 100ps

module kmeans_point_clustering_unit_tb;

  typedef struct {
    logic [3:0]         cidx;
    logic [10:0]        csize;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [3:0]         pclu;
    logic               conv;
    logic [9:0]         iters;
    logic               err;
    logic               last;
  } cluster_word_t;

  localparam int INVALID_CL = kpc_pkg::MAX_CLUSTERS;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [kpc_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic action;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic last_point;
  logic [9:0] point_index;
  logic out_valid;
  logic out_ready;
  logic [3:0] cluster_index;
  logic [10:0] cluster_size;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic signed [15:0] center_z;
  logic [3:0] point_cluster;
  logic converged;
  logic [9:0] iterations;
  logic error;
  logic last_result;

  kmeans_point_clustering_unit uut (.*);

  // predictor state
  int pts [kpc_pkg::MAX_POINTS][3];
  int assign_q [kpc_pkg::MAX_POINTS];
  longint ctr [kpc_pkg::MAX_CLUSTERS][3];
  int members [kpc_pkg::MAX_CLUSTERS];
  int n_loaded;
  int iter_cnt;
  int k_reg;
  int iter_reg;
  bit set_done;
  bit ovf;
  bit run_ok;
  bit run_conv;

  cluster_word_t expected_words [$];
  int n_err = 0;
  int n_words = 0;
  int n_runs;
  int n_reads;
  longint cycles = 0;
  int stall_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side idles in random stretches
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      out_ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_ready <= 1'b1;
      stall_cnt <= rand_gap();
    end
  end

  always @(posedge clk) begin
    cluster_word_t e;
    if (!rst && out_valid && out_ready) begin
      n_words++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word");
        n_err++;
      end else begin
        e = expected_words.pop_front();
        if (cluster_index !== e.cidx) begin
          $error("cluster_index exp %0d got %0d", e.cidx, cluster_index); n_err++; end
        if (cluster_size !== e.csize) begin
          $error("cluster_size exp %0d got %0d", e.csize, cluster_size); n_err++; end
        if (center_x !== e.cx) begin
          $error("center_x exp %0d got %0d", e.cx, center_x); n_err++; end
        if (center_y !== e.cy) begin
          $error("center_y exp %0d got %0d", e.cy, center_y); n_err++; end
        if (center_z !== e.cz) begin
          $error("center_z exp %0d got %0d", e.cz, center_z); n_err++; end
        if (point_cluster !== e.pclu) begin
          $error("point_cluster exp %0d got %0d", e.pclu, point_cluster); n_err++; end
        if (converged !== e.conv) begin
          $error("converged exp %0d got %0d", e.conv, converged); n_err++; end
        if (iterations !== e.iters) begin
          $error("iterations exp %0d got %0d", e.iters, iterations); n_err++; end
        if (error !== e.err) begin
          $error("error exp %0d got %0d", e.err, error); n_err++; end
        if (last_result !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, last_result); n_err++; end
      end
    end
  end

  function automatic cluster_word_t blank_word();
    cluster_word_t w;
    w = '{default: '0};
    return w;
  endfunction

  function automatic void queue_word(cluster_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void lloyd_run(int k);
    longint sums [kpc_pkg::MAX_CLUSTERS][3];
    longint best_d, d, e;
    int best, lim;
    bit changed;
    lim = (iter_reg == 0) ? 1 : iter_reg;
    for (int i = 0; i < n_loaded; i++) assign_q[i] = INVALID_CL;
    for (int j = 0; j < k; j++)
      for (int a = 0; a < 3; a++) ctr[j][a] = pts[j][a];
    iter_cnt = 0;
    run_conv = 1'b0;
    while (iter_cnt < lim) begin
      changed = 1'b0;
      for (int i = 0; i < n_loaded; i++) begin
        best = 0;
        best_d = 0;
        for (int j = 0; j < k; j++) begin
          d = 0;
          for (int a = 0; a < 3; a++) begin
            e = pts[i][a] - ctr[j][a];
            d += e * e;
          end
          if (j == 0 || d < best_d) begin
            best_d = d;
            best = j;
          end
        end
        if (assign_q[i] != best) begin
          assign_q[i] = best;
          changed = 1'b1;
        end
      end
      for (int j = 0; j < kpc_pkg::MAX_CLUSTERS; j++) begin
        members[j] = 0;
        for (int a = 0; a < 3; a++) sums[j][a] = 0;
      end
      for (int i = 0; i < n_loaded; i++) begin
        members[assign_q[i]]++;
        for (int a = 0; a < 3; a++) sums[assign_q[i]][a] += pts[i][a];
      end
      for (int j = 0; j < k; j++)
        if (members[j] != 0)
          for (int a = 0; a < 3; a++) ctr[j][a] = sums[j][a] / members[j];
      iter_cnt++;
      if (!changed) begin
        run_conv = 1'b1;
        break;
      end
    end
    run_ok = 1'b1;
  endfunction

  function automatic void predict_word(bit act, logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z, bit lp, logic [9:0] idx);
    cluster_word_t w;
    int k;
    w = blank_word();
    if (act == kpc_pkg::ACT_READ) begin
      if (run_ok && idx < n_loaded) w.pclu = 4'(assign_q[idx]);
      else w.err = 1'b1;
      w.last = 1'b1;
      queue_word(w);
      n_reads++;
      return;
    end
    if (set_done) begin
      set_done = 1'b0;
      n_loaded = 0;
      ovf = 1'b0;
      run_ok = 1'b0;
      run_conv = 1'b0;
    end
    if (n_loaded < kpc_pkg::MAX_POINTS) begin
      pts[n_loaded][0] = int'(x);
      pts[n_loaded][1] = int'(y);
      pts[n_loaded][2] = int'(z);
      n_loaded++;
    end else ovf = 1'b1;
    if (!lp) return;
    set_done = 1'b1;
    k = (k_reg == 0) ? 1 : k_reg;
    if (k > kpc_pkg::MAX_CLUSTERS) k = kpc_pkg::MAX_CLUSTERS;
    if (ovf || n_loaded < k) begin
      run_ok = 1'b0;
      run_conv = 1'b0;
      iter_cnt = 0;
      w.err = 1'b1;
      w.last = 1'b1;
      queue_word(w);
      return;
    end
    lloyd_run(k);
    n_runs++;
    for (int j = 0; j < k; j++) begin
      w = blank_word();
      w.cidx = 4'(j);
      w.csize = 11'(members[j]);
      w.cx = 16'(ctr[j][0]);
      w.cy = 16'(ctr[j][1]);
      w.cz = 16'(ctr[j][2]);
      w.conv = run_conv;
      w.iters = 10'(iter_cnt);
      w.last = (j + 1 == k);
      queue_word(w);
    end
  endfunction

  // in_valid stays high after an accept until the next call or an idle task lowers it
  task automatic send_word(bit act, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, bit lp, logic [9:0] idx, bit gaps = 1);
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    last_point <= lp;
    point_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(act, x, y, z, lp, idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic ri, int val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= kpc_pkg::CFG_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (ri == kpc_pkg::CFG_NUM_CLUSTERS) k_reg = val & 5'h1f;
    else iter_reg = val & 10'h3ff;
    @(posedge clk);
  endtask

  task automatic send_set(int n, int spread);
    logic signed [15:0] x, y, z;
    int cx, cy, cz;
    for (int i = 0; i < n; i++) begin
      if (spread == 0) begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end else begin
        cx = $urandom_range(0, 3) * 12000 - 18000;
        cy = $urandom_range(0, 3) * 12000 - 18000;
        cz = $urandom_range(0, 3) * 12000 - 18000;
        x = 16'(cx + $urandom_range(0, 2 * spread) - spread);
        y = 16'(cy + $urandom_range(0, 2 * spread) - spread);
        z = 16'(cz + $urandom_range(0, 2 * spread) - spread);
      end
      send_word(kpc_pkg::ACT_LOAD, x, y, z, i == n - 1, 10'($urandom));
    end
  endtask

  task automatic send_reads(int n);
    for (int i = 0; i < n; i++)
      send_word(kpc_pkg::ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                1'($urandom_range(0, 1)),
                $urandom_range(0, 9) < 8 ? 10'($urandom_range(0, n_loaded)) : 10'($urandom));
  endtask

  task automatic test_directed();
    send_word(kpc_pkg::ACT_READ, 0, 0, 0, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, 16'sh7fff, -16'sd32768, 0, 1, 0);
    send_word(kpc_pkg::ACT_READ, 0, 0, 0, 0, 1);
    drain();
    send_word(kpc_pkg::ACT_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, 0, 0, 0, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, 16'sh7fff, 0, -16'sd32768, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, 5, 5, 5, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, -16'sd32768, -16'sd32768, -16'sd32767, 1, 0);
    send_word(kpc_pkg::ACT_READ, 0, 0, 0, 0, 0);
    send_word(kpc_pkg::ACT_READ, 0, 0, 0, 0, 5);
    send_word(kpc_pkg::ACT_READ, 0, 0, 0, 0, 6);
    send_word(kpc_pkg::ACT_READ, 16'shffff, 16'shffff, 16'shffff, 1, 10'h3ff);
    drain();
    // duplicate points force distance ties
    write_reg(kpc_pkg::CFG_NUM_CLUSTERS, 3);
    repeat (4) send_word(kpc_pkg::ACT_LOAD, 100, -100, 7, 0, 0);
    send_word(kpc_pkg::ACT_LOAD, 100, -100, 7, 1, 0);
    send_word(kpc_pkg::ACT_READ, 0, 0, 0, 0, 4);
    drain();
  endtask

  task automatic test_settings();
    write_reg(kpc_pkg::CFG_NUM_CLUSTERS, 1);
    write_reg(kpc_pkg::CFG_MAX_ITER, 1);
    send_set(6, 500);
    send_reads(3);
    drain();
    write_reg(kpc_pkg::CFG_NUM_CLUSTERS, 16);
    write_reg(kpc_pkg::CFG_MAX_ITER, 1023);
    send_set(20, 3000);
    send_reads(3);
    drain();
    write_reg(kpc_pkg::CFG_NUM_CLUSTERS, 0);
    write_reg(kpc_pkg::CFG_MAX_ITER, 0);
    send_set(4, 0);
    drain();
    write_reg(kpc_pkg::CFG_NUM_CLUSTERS, 31);
    write_reg(kpc_pkg::CFG_MAX_ITER, 2);
    send_set(18, 0);
    send_set(5, 0);
    drain();
  endtask

  task automatic test_random();
    int n;
    for (int r = 0; r < 8; r++) begin
      write_reg(kpc_pkg::CFG_NUM_CLUSTERS, $urandom_range(1, 8));
      write_reg(kpc_pkg::CFG_MAX_ITER, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 100);
      n = $urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : $urandom_range(6, 14);
      send_set(n, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 4000));
      send_reads($urandom_range(1, 4));
      if (r == 3) drain();
    end
    drain();
  endtask

  initial begin
    n_runs = 0; n_reads = 0;
    k_reg = 4; iter_reg = 100;
    n_loaded = 0; iter_cnt = 0;
    set_done = 0; ovf = 0; run_ok = 0; run_conv = 0;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; action = 1'b0;
    coord_x = '0; coord_y = '0; coord_z = '0;
    last_point = 1'b0; point_index = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_random();
    $display("checked %0d result words: %0d clustering runs, %0d cluster reads",
             n_words, n_runs, n_reads);
    $display("covered register extremes, ties, too few points and random point clouds");
    if (n_err == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
